FILE: hdl/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg
// Types and constants for the source tokenizer: token codes, scanner modes,
// character codes, the keyword table and the token bundle type.
// ----------------------------------------------------------------------------
package stk_pkg;

  // most tokens one byte can produce
  localparam int MAX_RES = 3;
  // depth of the bundle queue between scanner and output
  localparam int QDEPTH = 4;

  // scanner modes
  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_OP     = 4'd1,
    M_SLASH  = 4'd2,
    M_LINE   = 4'd3,
    M_BLOCK  = 4'd4,
    M_BSTAR  = 4'd5,
    M_STRING = 4'd6,
    M_NUM    = 4'd7,
    M_NUMDOT = 4'd8,
    M_FRAC   = 4'd9,
    M_IDENT  = 4'd10
  } mode_t;

  // token kinds
  localparam logic [4:0] K_NUMBER = 5'd0;
  localparam logic [4:0] K_IDENT  = 5'd1;
  localparam logic [4:0] K_PLUS   = 5'd9;
  localparam logic [4:0] K_MINUS  = 5'd10;
  localparam logic [4:0] K_STAR   = 5'd11;
  localparam logic [4:0] K_SLASH  = 5'd12;
  localparam logic [4:0] K_ASSIGN = 5'd13;
  localparam logic [4:0] K_BANG   = 5'd15;
  localparam logic [4:0] K_LT     = 5'd17;
  localparam logic [4:0] K_GT     = 5'd19;
  localparam logic [4:0] K_SEMI   = 5'd21;
  localparam logic [4:0] K_COMMA  = 5'd22;
  localparam logic [4:0] K_LPAREN = 5'd23;
  localparam logic [4:0] K_RPAREN = 5'd24;
  localparam logic [4:0] K_LBRACE = 5'd25;
  localparam logic [4:0] K_RBRACE = 5'd26;
  localparam logic [4:0] K_EOF    = 5'd27;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CHAR   = 2'd1;
  localparam logic [1:0] ERR_STRING = 2'd2;

  // character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // keyword table, first character in the low byte
  localparam int NKW = 7;
  localparam logic [63:0] KW_TEXT [NKW] = '{
    64'h0000_0000_0074_656C,   // let
    64'h6E6F_6974_636E_7566,   // function
    64'h0000_0000_0000_6669,   // if
    64'h0000_0000_6573_6C65,   // else
    64'h0000_0065_6C69_6877,   // while
    64'h0000_0074_6E69_7270,   // print
    64'h0000_6E72_7574_6572    // return
  };
  localparam int KW_LEN [NKW] = '{3, 8, 2, 4, 5, 5, 6};
  localparam logic [4:0] KW_KIND [NKW] = '{5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8};

  // one result item
  typedef struct packed {
    logic [4:0]  kind;
    logic [19:0] start;
    logic [20:0] length;
    logic [20:0] line;
    logic [20:0] column;
    logic [1:0]  err;
    logic [7:0]  bad;
  } token_t;

  // all tokens caused by one input item
  typedef struct packed {
    token_t [MAX_RES-1:0] toks;
    logic   [1:0]         count;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ)) ||
           (b == CH_UNDER);
  endfunction

  function automatic logic [4:0] op_base(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      CH_EQ:   k = K_ASSIGN;
      CH_BANG: k = K_BANG;
      CH_LT:   k = K_LT;
      default: k = K_GT;
    endcase
    return k;
  endfunction

endpackage

FILE: hdl/stk_front.sv
// ----------------------------------------------------------------------------
// stk_front
// Scanner front end: takes one source byte per item, updates the scanner
// state and produces the bundle of tokens that the byte completes.
// ----------------------------------------------------------------------------
module stk_front #(
  parameter int SOURCE_BYTES  = 1048576,
  parameter int KEYWORD_CHARS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_source_byte,
  input  logic            in_end_of_source,
  input  logic            q_full,
  output logic            q_push,
  output stk_pkg::bundle_t q_data
);
  import stk_pkg::*;

  localparam int CW  = $clog2(SOURCE_BYTES + 2);
  localparam int ILW = $clog2(KEYWORD_CHARS + 2);
  localparam int ICW = KEYWORD_CHARS * 8;
  localparam logic [CW-1:0] SB     = CW'(SOURCE_BYTES);
  localparam logic [CW-1:0] SB_M1  = CW'(SOURCE_BYTES - 1);
  localparam logic [CW-1:0] SB_P1  = CW'(SOURCE_BYTES + 1);

  // scanner state
  mode_t            mode_r, mode_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [CW-1:0]    tstart_r, tstart_nxt;
  logic [CW-1:0]    boff_r, boff_nxt;
  logic [CW-1:0]    line_r, line_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [ICW-1:0]   ichars_r, ichars_nxt;
  logic [ILW-1:0]   ilen_r, ilen_nxt;
  logic             halt_r, halt_nxt;

  // working copies for the byte being scanned
  mode_t            m;
  logic [7:0]       hb;
  logic [CW-1:0]    ts, bo, ln, cl, span;
  logic [ICW-1:0]   ic;
  logic [ILW-1:0]   il;
  logic             hl;
  logic [1:0]       n;
  token_t [MAX_RES-1:0] toks;
  logic             do_idle, is_single;
  logic [7:0]       ib;
  logic [4:0]       sk;
  logic [7:0]       b;
  logic             accept;

  function automatic logic [CW-1:0] inc_off(input logic [CW-1:0] v);
    return (v < SB) ? v + 1'b1 : SB;
  endfunction

  function automatic logic [CW-1:0] inc_lc(input logic [CW-1:0] v);
    return (v < SB_P1) ? v + 1'b1 : SB_P1;
  endfunction

  function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v);
    return (v < SB) ? v : SB_M1;
  endfunction

  function automatic token_t mk_tok(input logic [4:0] kind, input logic [CW-1:0] s,
                                    input logic [CW-1:0] len, input logic [CW-1:0] l,
                                    input logic [CW-1:0] c, input logic [1:0] e,
                                    input logic [7:0] bad);
    token_t     t;
    logic [31:0] s32, len32, l32, c32;
    s32 = 32'(s);
    len32 = 32'(len);
    l32 = 32'(l);
    c32 = 32'(c);
    t.kind = kind;
    t.start = s32[19:0];
    t.length = len32[20:0];
    t.line = l32[20:0];
    t.column = c32[20:0];
    t.err = e;
    t.bad = bad;
    return t;
  endfunction

  // keyword lookup on the kept identifier characters
  function automatic logic [4:0] kw_kind(input logic [ICW-1:0] c, input logic [ILW-1:0] l);
    logic [4:0] kind;
    logic       ok;
    kind = K_IDENT;
    for (int k = 0; k < NKW; k++) begin
      ok = (l == ILW'(KW_LEN[k]));
      for (int i = 0; i < 8; i++) begin
        if ((i < KW_LEN[k]) && (c[i*8 +: 8] != KW_TEXT[k][i*8 +: 8])) ok = 1'b0;
      end
      if (ok && (kind == K_IDENT)) kind = KW_KIND[k];
    end
    return kind;
  endfunction

  assign b        = in_source_byte;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // byte scan, in the order the tokens are produced
  always_comb begin
    m = mode_r; hb = held_r; ts = tstart_r; bo = boff_r; ln = line_r; cl = col_r;
    ic = ichars_r; il = ilen_r; hl = halt_r;
    n = 2'd0; toks = '0; do_idle = 1'b0; ib = b; is_single = 1'b0; sk = K_PLUS;
    span = '0;
    if (!hl) begin
      case (m)
        M_OP: begin
          if (b == CH_EQ) begin
            bo = inc_off(bo); cl = inc_lc(cl);
            toks[n] = mk_tok(op_base(hb) + 5'd1, ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
            m = M_IDLE;
          end else begin
            toks[n] = mk_tok(op_base(hb), ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_SLASH: begin
          if (b == CH_SLASH) begin
            bo = inc_off(bo); cl = inc_lc(cl); m = M_LINE;
          end else if (b == CH_STAR) begin
            bo = inc_off(bo); cl = inc_lc(cl); m = M_BLOCK;
          end else begin
            toks[n] = mk_tok(K_SLASH, ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_LINE: begin
          if (b == CH_LF) do_idle = 1'b1;
          else begin
            bo = inc_off(bo); cl = inc_lc(cl);
          end
        end
        M_BLOCK, M_BSTAR: begin
          if ((m == M_BSTAR) && (b == CH_SLASH)) begin
            bo = inc_off(bo); cl = inc_lc(cl); m = M_IDLE;
          end else begin
            if (b == CH_LF) begin
              ln = inc_lc(ln); cl = CW'(1);
            end
            bo = inc_off(bo); cl = inc_lc(cl);
            m = (b == CH_STAR) ? M_BSTAR : M_BLOCK;
          end
        end
        M_STRING: begin
          if (b == CH_QUOTE) begin
            bo = inc_off(bo); cl = inc_lc(cl);
            span = bo - ts;
            toks[n] = mk_tok(K_IDENT, ts + 1'b1, (span >= CW'(2)) ? span - CW'(2) : '0,
                             ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
            m = M_IDLE;
          end else begin
            if (b == CH_LF) begin
              ln = inc_lc(ln); cl = CW'(1);
            end
            bo = inc_off(bo); cl = inc_lc(cl);
          end
        end
        M_NUM, M_FRAC: begin
          if (is_digit(b)) begin
            bo = inc_off(bo); cl = inc_lc(cl);
          end else if ((b == CH_DOT) && (m == M_NUM)) begin
            m = M_NUMDOT;
          end else begin
            toks[n] = mk_tok(K_NUMBER, ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit(b)) begin
            bo = inc_off(bo); cl = inc_lc(cl);
            bo = inc_off(bo); cl = inc_lc(cl);
            m = M_FRAC;
          end else begin
            // the deferred dot becomes an unexpected character
            toks[n] = mk_tok(K_NUMBER, ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
            do_idle = 1'b1;
            ib = CH_DOT;
          end
        end
        M_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            bo = inc_off(bo); cl = inc_lc(cl);
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
              if ((il < ILW'(KEYWORD_CHARS)) && (il == ILW'(i))) ic[i*8 +: 8] = b;
            end
            if (il <= ILW'(KEYWORD_CHARS)) il = il + 1'b1;
          end else begin
            toks[n] = mk_tok(kw_kind(ic, il), ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // byte between tokens
      if (do_idle) begin
        ts = clamp(bo);
        bo = inc_off(bo); cl = inc_lc(cl);
        m = M_IDLE;
        case (ib)
          CH_SPACE, CH_TAB, CH_CR: ;
          CH_LF: begin
            ln = inc_lc(ln); cl = CW'(1);
          end
          CH_PLUS:   begin is_single = 1'b1; sk = K_PLUS;   end
          CH_MINUS:  begin is_single = 1'b1; sk = K_MINUS;  end
          CH_STAR:   begin is_single = 1'b1; sk = K_STAR;   end
          CH_SEMI:   begin is_single = 1'b1; sk = K_SEMI;   end
          CH_COMMA:  begin is_single = 1'b1; sk = K_COMMA;  end
          CH_LPAREN: begin is_single = 1'b1; sk = K_LPAREN; end
          CH_RPAREN: begin is_single = 1'b1; sk = K_RPAREN; end
          CH_LBRACE: begin is_single = 1'b1; sk = K_LBRACE; end
          CH_RBRACE: begin is_single = 1'b1; sk = K_RBRACE; end
          CH_EQ, CH_BANG, CH_LT, CH_GT: begin
            hb = ib; m = M_OP;
          end
          CH_SLASH: m = M_SLASH;
          CH_QUOTE: m = M_STRING;
          default: begin
            if (is_digit(ib)) m = M_NUM;
            else if (is_alpha(ib)) begin
              ic = '0; ic[7:0] = ib; il = ILW'(1); m = M_IDENT;
            end else begin
              toks[n] = mk_tok(K_NUMBER, ts, CW'(1), ln, cl, ERR_CHAR, ib);
              n = n + 2'd1;
              hl = 1'b1;
            end
          end
        endcase
        if (is_single) begin
          toks[n] = mk_tok(sk, ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
          n = n + 2'd1;
        end
      end
    end

    // end of source: flush, end-of-file unless an error halted the scan, back to reset state
    if (in_end_of_source) begin
      if (!hl) begin
        case (m)
          M_OP: begin
            toks[n] = mk_tok(op_base(hb), ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
          end
          M_SLASH: begin
            toks[n] = mk_tok(K_SLASH, ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
          end
          M_NUM, M_FRAC: begin
            toks[n] = mk_tok(K_NUMBER, ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
          end
          M_NUMDOT: begin
            toks[n] = mk_tok(K_NUMBER, ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
            ts = clamp(bo);
            bo = inc_off(bo); cl = inc_lc(cl);
            toks[n] = mk_tok(K_NUMBER, ts, CW'(1), ln, cl, ERR_CHAR, CH_DOT);
            n = n + 2'd1;
            hl = 1'b1;
          end
          M_IDENT: begin
            toks[n] = mk_tok(kw_kind(ic, il), ts, bo - ts, ln, cl, ERR_NONE, 8'd0);
            n = n + 2'd1;
          end
          M_STRING: begin
            toks[n] = mk_tok(K_NUMBER, ts, bo - ts, ln, cl, ERR_STRING, 8'd0);
            n = n + 2'd1;
            hl = 1'b1;
          end
          default: ;
        endcase
        if (!hl) begin
          toks[n] = mk_tok(K_EOF, clamp(bo), '0, ln, cl, ERR_NONE, 8'd0);
          n = n + 2'd1;
        end
      end
      m = M_IDLE; hb = 8'd0; ts = '0; bo = '0; ln = CW'(1); cl = CW'(1);
      ic = '0; il = '0; hl = 1'b0;
    end
  end

  // next state
  always_comb begin
    mode_nxt = mode_r; held_nxt = held_r; tstart_nxt = tstart_r; boff_nxt = boff_r;
    line_nxt = line_r; col_nxt = col_r; ichars_nxt = ichars_r; ilen_nxt = ilen_r;
    halt_nxt = halt_r;
    if (accept) begin
      mode_nxt = m; held_nxt = hb; tstart_nxt = ts; boff_nxt = bo;
      line_nxt = ln; col_nxt = cl; ichars_nxt = ic; ilen_nxt = il; halt_nxt = hl;
    end
  end

  // queue write
  always_comb begin
    q_push = accept && (n != 2'd0);
    q_data.toks = toks;
    q_data.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      held_r   <= 8'd0;
      tstart_r <= '0;
      boff_r   <= '0;
      line_r   <= CW'(1);
      col_r    <= CW'(1);
      ichars_r <= '0;
      ilen_r   <= '0;
      halt_r   <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      tstart_r <= tstart_nxt;
      boff_r   <= boff_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      ichars_r <= ichars_nxt;
      ilen_r   <= ilen_nxt;
      halt_r   <= halt_nxt;
    end
  end

endmodule

FILE: hdl/stk_queue.sv
// ----------------------------------------------------------------------------
// stk_queue
// Short queue of token bundles between the scanner and the output side.
// ----------------------------------------------------------------------------
module stk_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  stk_pkg::bundle_t wdata,
  input  logic             pop,
  output stk_pkg::bundle_t head,
  output logic             empty,
  output logic             full
);
  import stk_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  bundle_t        ent_r [DEPTH];
  logic [PW-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [NW-1:0]  cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == NW'(DEPTH));
  assign head  = ent_r[rptr_r];

  // pointer and fill updates
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    if (pop)  rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wptr_r] <= wdata;
  end

endmodule

FILE: hdl/stk_back.sv
// ----------------------------------------------------------------------------
// stk_back
// Output side: walks the tokens of the head bundle one per item and marks
// the last one of each bundle.
// ----------------------------------------------------------------------------
module stk_back (
  input  logic             clk,
  input  logic             rst_n,
  input  stk_pkg::bundle_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [4:0]       out_token_kind,
  output logic [19:0]      out_start_offset,
  output logic [20:0]      out_token_length,
  output logic [20:0]      out_line_number,
  output logic [20:0]      out_column_number,
  output logic [1:0]       out_error_code,
  output logic [7:0]       out_bad_byte,
  output logic             out_last_of_run
);
  import stk_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  token_t     tok;
  logic       last, take;

  assign tok  = head.toks[idx_r];
  assign last = (idx_r == head.count - 2'd1);
  assign take = out_valid && !out_stall;
  assign pop  = take && last;

  // token select
  always_comb begin
    out_valid         = !empty;
    out_token_kind    = tok.kind;
    out_start_offset  = tok.start;
    out_token_length  = tok.length;
    out_line_number   = tok.line;
    out_column_number = tok.column;
    out_error_code    = tok.err;
    out_bad_byte      = tok.bad;
    out_last_of_run   = last;
  end

  // position within the bundle
  always_comb begin
    idx_nxt = idx_r;
    if (take) idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

FILE: hdl/source_code_tokenizer.sv
// ----------------------------------------------------------------------------
// source_code_tokenizer
// Streaming lexer: source bytes in, tokens with position and error info out.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    source byte, end-of-source flag
//   out_     output     out_valid/out_stall  kind, span, line, column, error
//
// One byte is taken per cycle while the bundle queue has room. A byte yields
// zero to three tokens; the output side sends one token per cycle while
// out_stall is low, so a byte with k tokens takes k transfers. Reset (rst_n
// low, sync) empties the queue and returns the scanner to its idle state.
// Either side may stall; the queue of QDEPTH bundles absorbs the difference.
// ----------------------------------------------------------------------------
module source_code_tokenizer #(
  parameter int SOURCE_BYTES  = 1048576,
  parameter int KEYWORD_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_source_byte,
  input  logic        in_end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_token_kind,
  output logic [19:0] out_start_offset,
  output logic [20:0] out_token_length,
  output logic [20:0] out_line_number,
  output logic [20:0] out_column_number,
  output logic [1:0]  out_error_code,
  output logic [7:0]  out_bad_byte,
  output logic        out_last_of_run
);
  import stk_pkg::*;

  logic    q_push, q_pop, q_empty, q_full;
  bundle_t q_wdata, q_head;

  // scanner
  stk_front #(
    .SOURCE_BYTES  (SOURCE_BYTES),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_source_byte   (in_source_byte),
    .in_end_of_source (in_end_of_source),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_wdata)
  );

  // bundle queue
  stk_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  // token output
  stk_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .empty             (q_empty),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_token_kind    (out_token_kind),
    .out_start_offset  (out_start_offset),
    .out_token_length  (out_token_length),
    .out_line_number   (out_line_number),
    .out_column_number (out_column_number),
    .out_error_code    (out_error_code),
    .out_bad_byte      (out_bad_byte),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

FILE: hdl/stk_checker.sv
// ----------------------------------------------------------------------------
// stk_checker
// Port-level checks on the tokenizer's output behavior.
// ----------------------------------------------------------------------------
module stk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_token_kind,
  input logic [20:0] out_token_length,
  input logic [1:0]  out_error_code,
  input logic [7:0]  out_bad_byte
);
  import stk_pkg::*;

  // nothing to send right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("token shown right after reset");

  // a stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_token_kind) &&
    $stable(out_token_length))
    else $error("stalled token changed");

  // end-of-file carries no span
  a_eof_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == K_EOF) |-> (out_token_length == '0) &&
    (out_error_code == ERR_NONE))
    else $error("end-of-file with nonzero length");

  // bad byte only for unexpected characters
  a_bad_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_CHAR) |-> (out_bad_byte == 8'd0))
    else $error("bad byte without character error");

endmodule

bind source_code_tokenizer stk_checker u_stk_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_token_kind   (out_token_kind),
  .out_token_length (out_token_length),
  .out_error_code   (out_error_code),
  .out_bad_byte     (out_bad_byte)
);

FILE: tb/tb_token_checker.sv
// ----------------------------------------------------------------------------
// tb_token_checker
// Watches both channels of the source tokenizer, predicts the tokens that
// every accepted source byte produces and compares each token field by field.
// ----------------------------------------------------------------------------
module tb_token_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_source_byte,
  input  logic        in_end_of_source,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [4:0]  out_token_kind,
  input  logic [19:0] out_start_offset,
  input  logic [20:0] out_token_length,
  input  logic [20:0] out_line_number,
  input  logic [20:0] out_column_number,
  input  logic [1:0]  out_error_code,
  input  logic [7:0]  out_bad_byte,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          tokens_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import stk_pkg::*;

  localparam longint SRC_CAP = 1048576;
  localparam int ID_CHARS = 8;

  typedef struct packed {
    token_t tok;
    logic   last;
  } exp_token_t;

  // scanner state mirror
  mode_t       mode;
  logic [7:0]  held;
  longint      tok_start;
  longint      offset;
  longint      line_no;
  longint      col_no;
  logic [7:0]  id_text [ID_CHARS];
  int          id_len;
  logic        halted;

  exp_token_t  token_fifo [$];
  exp_token_t  step_tokens [$];

  assign tokens_pending = token_fifo.size();

  function automatic longint sat_inc(longint v, longint cap);
    return (v < cap) ? v + 1 : cap;
  endfunction

  task automatic scan_reset();
    mode = M_IDLE;
    held = '0;
    tok_start = 0;
    offset = 0;
    line_no = 1;
    col_no = 1;
    foreach (id_text[i]) id_text[i] = '0;
    id_len = 0;
    halted = 1'b0;
  endtask

  task automatic step_over();
    offset = sat_inc(offset, SRC_CAP);
    col_no = sat_inc(col_no, SRC_CAP + 1);
  endtask

  task automatic line_break();
    line_no = sat_inc(line_no, SRC_CAP + 1);
    col_no = 1;
  endtask

  function automatic longint clamped_offset();
    return (offset < SRC_CAP) ? offset : SRC_CAP - 1;
  endfunction

  task automatic add_token(logic [4:0] kind, longint st, longint len,
                           logic [1:0] err, logic [7:0] bad);
    exp_token_t e;
    if (step_tokens.size() >= MAX_RES) return;
    e.tok.kind = kind;
    e.tok.start = st[19:0];
    e.tok.length = len[20:0];
    e.tok.line = line_no[20:0];
    e.tok.column = col_no[20:0];
    e.tok.err = err;
    e.tok.bad = bad;
    e.last = 1'b0;
    step_tokens.insert(step_tokens.size(), e);
  endtask

  task automatic push_span(logic [4:0] kind);
    add_token(kind, tok_start, offset - tok_start, ERR_NONE, 8'h00);
  endtask

  function automatic logic [4:0] word_kind();
    logic [63:0] txt;
    txt = '0;
    for (int i = 0; i < ID_CHARS; i++) txt[8*i +: 8] = id_text[i];
    for (int k = 0; k < NKW; k++)
      if (id_len == KW_LEN[k] && txt == KW_TEXT[k]) return KW_KIND[k];
    return K_IDENT;
  endfunction

  task automatic byte_between_tokens(logic [7:0] b);
    logic [4:0] single;
    logic       found;
    found = 1'b1;
    single = '0;
    tok_start = clamped_offset();
    step_over();
    mode = M_IDLE;
    case (b)
      CH_SPACE, CH_TAB, CH_CR: return;
      CH_LF: begin
        line_break();
        return;
      end
      CH_PLUS:   single = K_PLUS;
      CH_MINUS:  single = K_MINUS;
      CH_STAR:   single = K_STAR;
      CH_SEMI:   single = K_SEMI;
      CH_COMMA:  single = K_COMMA;
      CH_LPAREN: single = K_LPAREN;
      CH_RPAREN: single = K_RPAREN;
      CH_LBRACE: single = K_LBRACE;
      CH_RBRACE: single = K_RBRACE;
      CH_EQ, CH_BANG, CH_LT, CH_GT: begin
        held = b;
        mode = M_OP;
        return;
      end
      CH_SLASH: begin
        mode = M_SLASH;
        return;
      end
      CH_QUOTE: begin
        mode = M_STRING;
        return;
      end
      default: found = 1'b0;
    endcase
    if (found) begin
      push_span(single);
      return;
    end
    if (b >= CH_0 && b <= CH_9) begin
      mode = M_NUM;
      return;
    end
    if ((b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ) || b == CH_UNDER) begin
      foreach (id_text[i]) id_text[i] = '0;
      id_text[0] = b;
      id_len = 1;
      mode = M_IDENT;
      return;
    end
    add_token(K_NUMBER, tok_start, 1, ERR_CHAR, b);
    halted = 1'b1;
  endtask

  function automatic logic [4:0] op_kind(logic [7:0] b);
    case (b)
      CH_EQ:   return K_ASSIGN;
      CH_BANG: return K_BANG;
      CH_LT:   return K_LT;
      default: return K_GT;
    endcase
  endfunction

  function automatic logic digit(logic [7:0] b);
    return b >= CH_0 && b <= CH_9;
  endfunction

  function automatic logic word_char(logic [7:0] b);
    return (b >= CH_LA && b <= CH_LZ) || (b >= CH_UA && b <= CH_UZ) ||
           b == CH_UNDER || digit(b);
  endfunction

  task automatic scan(logic [7:0] b);
    longint span;
    case (mode)
      M_OP: begin
        if (b == CH_EQ) begin
          step_over();
          push_span(op_kind(held) + 5'd1);
          mode = M_IDLE;
        end else begin
          push_span(op_kind(held));
          byte_between_tokens(b);
        end
      end
      M_SLASH: begin
        if (b == CH_SLASH) begin
          step_over();
          mode = M_LINE;
        end else if (b == CH_STAR) begin
          step_over();
          mode = M_BLOCK;
        end else begin
          push_span(K_SLASH);
          byte_between_tokens(b);
        end
      end
      M_LINE: begin
        if (b == CH_LF) byte_between_tokens(b);
        else step_over();
      end
      M_BLOCK, M_BSTAR: begin
        if (mode == M_BSTAR && b == CH_SLASH) begin
          step_over();
          mode = M_IDLE;
        end else begin
          if (b == CH_LF) line_break();
          step_over();
          mode = (b == CH_STAR) ? M_BSTAR : M_BLOCK;
        end
      end
      M_STRING: begin
        if (b == CH_QUOTE) begin
          step_over();
          span = offset - tok_start;
          add_token(K_IDENT, tok_start + 1, (span >= 2) ? span - 2 : 0, ERR_NONE, 8'h00);
          mode = M_IDLE;
        end else begin
          if (b == CH_LF) line_break();
          step_over();
        end
      end
      M_NUM, M_FRAC: begin
        if (digit(b)) step_over();
        else if (b == CH_DOT && mode == M_NUM) mode = M_NUMDOT;
        else begin
          push_span(K_NUMBER);
          byte_between_tokens(b);
        end
      end
      M_NUMDOT: begin
        if (digit(b)) begin
          step_over();
          step_over();
          mode = M_FRAC;
        end else begin
          push_span(K_NUMBER);
          byte_between_tokens(CH_DOT);
          if (!halted) byte_between_tokens(b);
        end
      end
      M_IDENT: begin
        if (word_char(b)) begin
          step_over();
          if (id_len < ID_CHARS) id_text[id_len] = b;
          if (id_len <= ID_CHARS) id_len++;
        end else begin
          push_span(word_kind());
          byte_between_tokens(b);
        end
      end
      default: byte_between_tokens(b);
    endcase
  endtask

  // close the source: pending token, then end-of-file unless halted
  task automatic close_source();
    case (mode)
      M_OP:          push_span(op_kind(held));
      M_SLASH:       push_span(K_SLASH);
      M_NUM, M_FRAC: push_span(K_NUMBER);
      M_NUMDOT: begin
        push_span(K_NUMBER);
        byte_between_tokens(CH_DOT);
      end
      M_IDENT:       push_span(word_kind());
      M_STRING: begin
        add_token(K_NUMBER, tok_start, offset - tok_start, ERR_STRING, 8'h00);
        halted = 1'b1;
      end
      default: ;
    endcase
    mode = M_IDLE;
    if (!halted) add_token(K_EOF, clamped_offset(), 0, ERR_NONE, 8'h00);
  endtask

  task automatic predict_item(logic [7:0] b, logic last);
    step_tokens.delete();
    if (!halted) scan(b);
    if (last) begin
      if (!halted) close_source();
      scan_reset();
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
    foreach (step_tokens[i]) token_fifo.insert(token_fifo.size(), step_tokens[i]);
  endtask

  task automatic report(string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    exp_token_t e;
    if (!rst_n) begin
      scan_reset();
      token_fifo.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (token_fifo.size() == 0) begin
          report($sformatf("token with nothing expected, kind %0d", out_token_kind));
        end else begin
          e = token_fifo.pop_front();
          if (out_token_kind !== e.tok.kind)
            report($sformatf("kind exp %0d got %0d", e.tok.kind, out_token_kind));
          if (out_start_offset !== e.tok.start)
            report($sformatf("start exp %0d got %0d", e.tok.start, out_start_offset));
          if (out_token_length !== e.tok.length)
            report($sformatf("length exp %0d got %0d", e.tok.length, out_token_length));
          if (out_line_number !== e.tok.line)
            report($sformatf("line exp %0d got %0d", e.tok.line, out_line_number));
          if (out_column_number !== e.tok.column)
            report($sformatf("column exp %0d got %0d", e.tok.column, out_column_number));
          if (out_error_code !== e.tok.err)
            report($sformatf("error exp %0d got %0d", e.tok.err, out_error_code));
          if (out_bad_byte !== e.tok.bad)
            report($sformatf("bad byte exp %0h got %0h", e.tok.bad, out_bad_byte));
          if (out_last_of_run !== e.last)
            report($sformatf("last exp %0b got %0b", e.last, out_last_of_run));
        end
      end
      if (in_valid && !in_stall) predict_item(in_source_byte, in_end_of_source);
    end
  end

  initial begin
    fail_count = 0;
    scan_reset();
  end

endmodule

FILE: tb/tb_source_code_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_source_code_tokenizer
// Feeds the tokenizer directed and random source texts with random gaps on
// the byte side and random stalls on the token side; the checker module
// predicts and compares every token and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_source_code_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import stk_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_source_byte;
  logic        in_end_of_source;
  logic        out_valid;
  logic        out_stall;
  logic [4:0]  out_token_kind;
  logic [19:0] out_start_offset;
  logic [20:0] out_token_length;
  logic [20:0] out_line_number;
  logic [20:0] out_column_number;
  logic [1:0]  out_error_code;
  logic [7:0]  out_bad_byte;
  logic        out_last_of_run;
  int          fail_count;
  int          tokens_pending;
  int          cycle_count;
  logic        calm;
  int          items_sent;

  source_code_tokenizer dut (.*);

  tb_token_checker checker_i (.*);

  // clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // cycle limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // random receiver stalls, none during calm stretch
  always @(negedge clk) begin
    if (!rst_n || calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 27);
  end

  // send one byte, with a random gap before it unless calm; valid stays up between bytes with no gap
  task automatic send_byte(logic [7:0] b, logic last);
    if (!calm) begin
      while ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_source_byte <= b;
    in_end_of_source <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text(string s, logic close);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], close && (i == s.len() - 1));
  endtask

  // one random lexeme, mostly well formed
  task automatic send_lexeme();
    string words [12] = '{"let", "function", "if", "else", "while", "print",
                          "return", "functions", "x_1", "Zed", "abcdefghij", "_"};
    string ops [16] = '{"+", "-", "*", "/", "=", "==", "!", "!=", "<", "<=",
                        ">", ">=", ";", ",", "(", ")"};
    int n;
    case ($urandom_range(11))
      0, 1: send_text(words[$urandom_range(11)], 1'b0);
      2, 3: send_text(ops[$urandom_range(15)], 1'b0);
      4: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_byte(8'(CH_0 + $urandom_range(9)), 1'b0);
        if ($urandom_range(1)) begin
          send_byte(CH_DOT, 1'b0);
          if ($urandom_range(3)) send_byte(8'(CH_0 + $urandom_range(9)), 1'b0);
        end
      end
      5: begin
        send_byte(CH_QUOTE, 1'b0);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
          send_byte($urandom_range(3) ? 8'(CH_LA + $urandom_range(25)) : CH_LF, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
      end
      6: send_text($urandom_range(1) ? "// note\n" : "/* a*\nb **/", 1'b0);
      7: send_byte($urandom_range(1) ? CH_LF : CH_TAB, 1'b0);
      8: send_byte(8'(CH_LBRACE + 2 * $urandom_range(1)), 1'b0);
      9: send_byte(8'(CH_UA + $urandom_range(25)), 1'b0);
      10: send_byte(CH_SPACE, 1'b0);
      default: send_byte(8'($urandom_range(255)), 1'b0);
    endcase
    if ($urandom_range(2) == 0) send_byte(CH_SPACE, 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tokens_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_source_byte = '0;
    in_end_of_source = 1'b0;
    out_stall = 1'b0;
    calm = 1'b0;
    items_sent = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: operators, keywords, numbers, comments, strings, errors
    send_text("let x=10.5;if(a!=b){}", 1'b0);
    send_text("while<=>= print,return==!-*+/", 1'b1);
    send_text("function abcdefghij 7.x", 1'b1);
    send_text("\"a\nb\" /* c\n*/ // d\n3.", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_text("\"open", 1'b1);
    send_text("/* never", 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b1);
    // hold off until all tokens are out
    drain();

    // random sources
    while (items_sent < 430) begin
      calm = (items_sent > 200 && items_sent < 260);
      for (int t = $urandom_range(1, 12); t > 0; t--) send_lexeme();
      send_byte($urandom_range(3) ? CH_SPACE : 8'($urandom_range(255)), 1'b1);
    end
    calm = 1'b0;
    drain();

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
